[rtl/core/dhms_pkg.sv]
// Shared types, codes and tables for the debounced dual health mode selector.
// No dependencies; imported by every module of the block.
package dhms_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned NowWidth         = 32;
  localparam int unsigned DebounceWidth    = 20;
  localparam logic [DebounceWidth-1:0] DebounceReset = 20'd3000;

  // Input opcodes; the fourth code is unused and leaves all state alone.
  localparam logic [1:0] OpRecReport  = 2'd0;
  localparam logic [1:0] OpLiveReport = 2'd1;
  localparam logic [1:0] OpEvaluate   = 2'd2;

  // Queue leak policies.
  localparam logic [1:0] LeakNone       = 2'd0;
  localparam logic [1:0] LeakDropOldest = 2'd2;

  typedef enum logic [1:0] {
    MODE_FULL      = 2'd0,
    MODE_REC_ONLY  = 2'd1,
    MODE_LIVE_ONLY = 2'd2,
    MODE_DEGRADED  = 2'd3
  } mode_e;

  typedef struct packed {
    logic       rec_limit;
    logic [1:0] rec_leak;
    logic       live_limit;
    logic [1:0] live_leak;
  } queue_t;

  // Per-branch control for one transaction moving through the compute stage.
  typedef struct packed {
    logic fire;
    logic report;
    logic evaluate;
    logic status;
  } branch_ctl_t;

  // Mode from confirmed health (1 = unhealthy).
  function automatic mode_e mode_of(input logic rec_bad, input logic live_bad);
    mode_e m;
    unique case ({rec_bad, live_bad})
      2'b00:   m = MODE_FULL;
      2'b01:   m = MODE_REC_ONLY;
      2'b10:   m = MODE_LIVE_ONLY;
      default: m = MODE_DEGRADED;
    endcase
    return m;
  endfunction

  function automatic queue_t queue_of(input mode_e m);
    queue_t q;
    unique case (m)
      MODE_FULL:      q = '{1'b1, LeakNone,       1'b1, LeakDropOldest};
      MODE_REC_ONLY:  q = '{1'b1, LeakNone,       1'b0, LeakDropOldest};
      MODE_LIVE_ONLY: q = '{1'b0, LeakDropOldest, 1'b1, LeakDropOldest};
      default:        q = '{1'b1, LeakNone,       1'b0, LeakDropOldest};
    endcase
    return q;
  endfunction

endpackage

[rtl/core/debounced_dual_health_mode_select_top.sv]
// Top level of the debounced dual health mode selector: input register,
// mode logic, result register. Depends on dhms_pkg and dhms_branch.
//
// One result transaction per input transaction: an item is held in the
// input register, is evaluated against the branch state while held there
// and then moves into the result register; the block takes one item per
// clock while the result channel does not stall. The input side keeps
// accepting while a result waits, as long as the input register is free;
// it stalls only when both the input and result registers are occupied and
// the downstream stalls. Reports (opcode 0 recording, 1 live) record a new
// pending status with its timestamp; an evaluate (opcode 2) confirms each
// pending status whose modular age reaches debounce_time and recomputes the
// mode. Opcode 3 touches nothing. The debounce register (reset 3000 ms) is
// written through the cfg channel, which is always ready; write it only when
// no transaction is in flight.
module debounced_dual_health_mode_select_top #(
  parameter int unsigned TIME_WIDTH = dhms_pkg::TimeWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         opcode_i,
  input  logic                               status_i,
  input  logic [dhms_pkg::NowWidth-1:0]      now_ms_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         mode_o,
  output logic                               mode_switch_o,
  output logic [1:0]                         previous_mode_o,
  output logic                               rec_confirmed_o,
  output logic                               live_confirmed_o,
  output logic                               rec_queue_limit_o,
  output logic [1:0]                         rec_queue_leak_o,
  output logic                               live_queue_limit_o,
  output logic [1:0]                         live_queue_leak_o,
  // configuration channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dhms_pkg::DebounceWidth-1:0] cfg_wdata_i
);
  import dhms_pkg::*;

  // Configuration register.
  logic [DebounceWidth-1:0] debounce_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  // Input register. Time is cut to TIME_WIDTH bits at entry.
  logic                  in_valid_q;
  logic [1:0]            opcode_q;
  logic                  status_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  in_accept;
  logic                  fire;
  logic                  out_valid_q;

  // fire: the held item moves into the result register this cycle.
  assign fire       = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q <= opcode_i;
      status_q <= status_i;
      now_q    <= TIME_WIDTH'(now_ms_i);
    end
  end

  // Branch trackers.
  branch_ctl_t rec_ctl, live_ctl;
  logic        rec_conf, live_conf;
  logic        is_eval;

  assign is_eval = (opcode_q == OpEvaluate);

  assign rec_ctl  = '{fire: fire, report: opcode_q == OpRecReport,
                      evaluate: is_eval, status: status_q};
  assign live_ctl = '{fire: fire, report: opcode_q == OpLiveReport,
                      evaluate: is_eval, status: status_q};

  dhms_branch #(.TimeWidth(TIME_WIDTH)) u_rec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (rec_ctl),
    .now_i       (now_q),
    .debounce_i  (debounce_q),
    .confirmed_o (rec_conf)
  );

  dhms_branch #(.TimeWidth(TIME_WIDTH)) u_live (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (live_ctl),
    .now_i       (now_q),
    .debounce_i  (debounce_q),
    .confirmed_o (live_conf)
  );

  // Mode: only an evaluate can move it.
  mode_e  mode_q, mode_d, target;
  logic   changed;
  queue_t queue;

  assign target  = mode_of(rec_conf, live_conf);
  assign mode_d  = is_eval ? target : mode_q;
  assign changed = is_eval && (target != mode_q);
  assign queue   = queue_of(mode_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FULL;
    end else if (fire) begin
      mode_q <= mode_d;
    end
  end

  // Result register.
  mode_e  res_mode_q, res_prev_q;
  logic   res_changed_q, res_rec_q, res_live_q;
  queue_t res_queue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_mode_q    <= mode_d;
      res_prev_q    <= mode_q;
      res_changed_q <= changed;
      res_rec_q     <= rec_conf;
      res_live_q    <= live_conf;
      res_queue_q   <= queue;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mode_o             = res_mode_q;
  assign mode_switch_o      = res_changed_q;
  assign previous_mode_o    = res_prev_q;
  assign rec_confirmed_o    = res_rec_q;
  assign live_confirmed_o   = res_live_q;
  assign rec_queue_limit_o  = res_queue_q.rec_limit;
  assign rec_queue_leak_o   = res_queue_q.rec_leak;
  assign live_queue_limit_o = res_queue_q.live_limit;
  assign live_queue_leak_o  = res_queue_q.live_leak;

  // Assertions.
  a_change_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_switch_o |-> mode_o != previous_mode_o)
    else $error("switch flag set without a mode change");

  a_mode_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> mode_o == mode_q)
    else $error("result mode disagrees with held mode");

  a_no_change_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_switch_o |-> mode_o == previous_mode_o)
    else $error("mode moved without the switch flag");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with a free pipeline");

endmodule

[rtl/core/dhms_branch.sv]
// Pending/confirmed health tracker for one branch, with wrap-safe debounce age.
// Depends on dhms_pkg.
module dhms_branch #(
  parameter int unsigned TimeWidth = dhms_pkg::TimeWidthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dhms_pkg::branch_ctl_t                ctl_i,
  input  logic [TimeWidth-1:0]                 now_i,
  input  logic [dhms_pkg::DebounceWidth-1:0]   debounce_i,
  output logic                                 confirmed_o
);
  import dhms_pkg::*;

  localparam int unsigned CmpWidth =
      (TimeWidth > DebounceWidth) ? TimeWidth : DebounceWidth;

  logic                 pending_q, pending_d;
  logic                 confirmed_q, confirmed_d;
  logic [TimeWidth-1:0] stamp_q, stamp_d;
  logic [TimeWidth-1:0] age;
  logic                 aged;

  assign age  = now_i - stamp_q;
  assign aged = CmpWidth'(age) >= CmpWidth'(debounce_i);

  always_comb begin
    pending_d   = pending_q;
    stamp_d     = stamp_q;
    confirmed_d = confirmed_q;
    if (ctl_i.report && (ctl_i.status != pending_q)) begin
      pending_d = ctl_i.status;
      stamp_d   = now_i;
    end
    if (ctl_i.evaluate && (pending_q != confirmed_q) && aged) begin
      confirmed_d = pending_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      confirmed_q <= 1'b0;
      stamp_q     <= '0;
    end else if (ctl_i.fire) begin
      pending_q   <= pending_d;
      confirmed_q <= confirmed_d;
      stamp_q     <= stamp_d;
    end
  end

  // Confirmed status as it stands after the current transaction.
  assign confirmed_o = confirmed_d;

endmodule
